// File: rtl/core/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the stepper ramp generator
// Field widths, command and phase codes, divider and multiplier requests.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int SPEED_W  = 32;
  localparam int DELAY_W  = 30;
  localparam int MAXSP_W  = 16;
  localparam int MINSP_W  = 10;
  localparam int CNT_W    = 17;
  localparam int IDX_W    = 16;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_W      = 32;
  localparam int DIV_ITER_W = 6;
  localparam int MUL_A_W    = 15;
  localparam int MUL_B_W    = 30;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = 4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_IDLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 2'd1;

  localparam logic [DELAY_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Divider operands for 1e9 / start speed: 30 quotient bits, empty remainder.
  localparam logic [DIV_W-1:0] START_NUM_LOW = {NS_PER_SEC, 2'b00};
  // Divider operands for (1e9 << 16) / speed: the bits above the low 30
  // quotient positions seed the remainder.
  localparam logic [DIV_W-1:0] DLY_REM_INIT = {16'd0, NS_PER_SEC[29:14]};
  localparam logic [DIV_W-1:0] DLY_NUM_LOW  = {NS_PER_SEC[13:0], 18'd0};

  localparam logic [DIV_ITER_W-1:0] DIV_ITERS_DELAY = 6'd30;
  localparam logic [DIV_ITER_W-1:0] DIV_ITERS_INC   = 6'd32;

  typedef struct packed {
    logic                  start;
    logic [DIV_ITER_W-1:0] iters;
    logic [DIV_W-1:0]      rem_init;
    logic [DIV_W-1:0]      num_low;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mplier;
    logic [MUL_B_W-1:0] mcand;
  } mul_req_t;

endpackage

// File: rtl/core/stepper_trapezoid_profile_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_unit: trapezoidal stepper ramp generator
// Start requests load a move; step requests return the delay of each step.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A start request runs the 30
// iterations of the bit-serial divider that forms 1e9 over the start
// speed; it returns no result. An accelerating step runs the shift-add
// multiplier, then 32 divider iterations for the speed increment and 30
// for the new delay. A decelerating step adds to a cruising step the
// registered read of the ramp store. Results sit in an output register, so a
// new request is taken while the previous result waits. The ramp store needs
// no clearing: a move only reads back entries it wrote itself.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile_unit #(
  parameter int MAX_STEPS  = 65536,
  parameter int RAMP_DEPTH = 32768
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic [stp_pkg::CNT_W-1:0]        in_step_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stp_pkg::DELAY_W-1:0]      out_delay_ns,
  output logic [stp_pkg::IDX_W-1:0]        out_step_index,
  output logic [stp_pkg::PHASE_W-1:0]      out_phase,
  output logic                             out_pin_level,
  output logic                             out_last,
  output logic                             out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stp_pkg::*;

  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int RW  = $clog2(RAMP_DEPTH + 1);
  localparam int CW0 = (SW > CNT_W) ? SW : CNT_W;
  localparam int CW  = (CW0 > RW) ? CW0 : RW;
  localparam int AW  = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START_DIV,
    S_MUL,
    S_INC_DIV,
    S_DLY_DIV,
    S_RD,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [MAXSP_W-1:0] max_speed_r, max_speed_nxt;
  logic [MINSP_W-1:0] start_speed_r, start_speed_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [SW-1:0]      pos_r, pos_nxt;
  logic [SW-1:0]      len_r, len_nxt;
  logic [SW-1:0]      cap_step_r, cap_step_nxt;
  logic               cap_r, cap_nxt;
  logic               active_r, active_nxt;

  logic [DELAY_W-1:0] res_delay_r, res_delay_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [PHASE_W-1:0] res_phase_r, res_phase_nxt;
  logic               res_pin_r, res_pin_nxt;
  logic               res_last_r, res_last_nxt;
  logic               res_status_r, res_status_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DELAY_W-1:0] out_delay_r, out_delay_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [PHASE_W-1:0] out_phase_r, out_phase_nxt;
  logic               out_pin_r, out_pin_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_status_r, out_status_nxt;

  logic [MINSP_W-1:0] mn;
  logic [MAXSP_W-1:0] mx;
  logic [SW-1:0]      half_len;
  logic [SW-1:0]      limit;
  logic [SW-1:0]      ramp_count;
  logic [SW-1:0]      pos_inc;
  logic [SW-1:0]      rd_idx;
  logic [SW-1:0]      sat_cnt;
  logic               accel_go;
  logic               decel_go;
  logic               no_move;
  logic               in_acc;
  logic [SPEED_W:0]   sp_sum;
  logic [SPEED_W:0]   cap_val;
  logic               sp_capped;
  logic [SPEED_W-1:0] sp_new;

  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  mul_req_t           mul_req;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [DELAY_W-1:0] ram_rdata;

  stp_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  stp_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  stp_ram #(
    .WIDTH (DELAY_W),
    .DEPTH (RAMP_DEPTH),
    .AW    (AW)
  ) u_ramp_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_quot[DELAY_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    mn = (start_speed_r == '0) ? MINSP_W'(1) : start_speed_r;
    mx = (max_speed_r == '0) ? MAXSP_W'(1) : max_speed_r;

    half_len = len_r >> 1;
    limit    = (CW'(half_len) > CW'(RAMP_DEPTH)) ? SW'(RAMP_DEPTH) : half_len;
    // Once the cap is hit, the deceleration replays entries up to the cap step.
    ramp_count = cap_r ? SW'(cap_step_r + 1'b1) : limit;
    accel_go   = !cap_r && (pos_r < limit);
    decel_go   = pos_r >= SW'(len_r - ramp_count);
    no_move    = !active_r || (pos_r >= len_r);
    pos_inc    = SW'(pos_r + 1'b1);
    rd_idx     = SW'(len_r - pos_r - 1'b1);
    sat_cnt    = (CW'(in_step_count) > CW'(MAX_STEPS)) ? SW'(MAX_STEPS)
                                                        : SW'(in_step_count);

    sp_sum    = {1'b0, speed_r} + {1'b0, div_quot};
    cap_val   = {1'b0, mx, 16'd0};
    sp_capped = sp_sum > cap_val;
    sp_new    = sp_capped ? cap_val[SPEED_W-1:0] : sp_sum[SPEED_W-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    max_speed_nxt   = max_speed_r;
    start_speed_nxt = start_speed_r;
    speed_nxt       = speed_r;
    delay_nxt       = delay_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    cap_step_nxt    = cap_step_r;
    cap_nxt         = cap_r;
    active_nxt      = active_r;
    res_delay_nxt   = res_delay_r;
    res_idx_nxt     = res_idx_r;
    res_phase_nxt   = res_phase_r;
    res_pin_nxt     = res_pin_r;
    res_last_nxt    = res_last_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_delay_nxt   = out_delay_r;
    out_idx_nxt     = out_idx_r;
    out_phase_nxt   = out_phase_r;
    out_pin_nxt     = out_pin_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;

    div_req   = '0;
    mul_req   = '0;
    ram_we    = 1'b0;
    ram_waddr = AW'(pos_r);
    ram_re    = 1'b0;
    ram_raddr = AW'(rd_idx);

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_SPEED:   max_speed_nxt   = cfg_data[MAXSP_W-1:0];
        REG_START_SPEED: start_speed_nxt = cfg_data[MINSP_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_START) begin
            len_nxt      = sat_cnt;
            pos_nxt      = '0;
            cap_step_nxt = '0;
            cap_nxt      = 1'b0;
            speed_nxt    = {6'd0, mn, 16'd0};
            active_nxt   = (sat_cnt != '0);
            div_req.start    = 1'b1;
            div_req.iters    = DIV_ITERS_DELAY;
            div_req.rem_init = '0;
            div_req.num_low  = START_NUM_LOW;
            div_req.divisor  = DIV_W'(mn);
            state_nxt = S_START_DIV;
          end else if (no_move) begin
            active_nxt     = 1'b0;
            res_delay_nxt  = '0;
            res_idx_nxt    = '0;
            res_phase_nxt  = PH_ACCEL;
            res_pin_nxt    = 1'b0;
            res_last_nxt   = 1'b0;
            res_status_nxt = STATUS_IDLE;
            state_nxt      = S_OUT;
          end else if (accel_go) begin
            mul_req.start  = 1'b1;
            mul_req.mplier = mx[MAXSP_W-1:1];
            mul_req.mcand  = delay_r;
            state_nxt      = S_MUL;
          end else if (decel_go) begin
            ram_re    = 1'b1;
            state_nxt = S_RD;
          end else begin
            res_delay_nxt  = delay_r;
            res_phase_nxt  = PH_CRUISE;
            res_idx_nxt    = IDX_W'(pos_r);
            res_pin_nxt    = ~pos_r[0];
            res_last_nxt   = (pos_inc == len_r);
            res_status_nxt = STATUS_OK;
            pos_nxt        = pos_inc;
            active_nxt     = (pos_inc < len_r);
            state_nxt      = S_OUT;
          end
        end
      end
      S_START_DIV: begin
        if (div_done) begin
          delay_nxt = div_quot[DELAY_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          // Increment is ((max speed / 2) * delay * 65536) / 1e9.
          div_req.start    = 1'b1;
          div_req.iters    = DIV_ITERS_INC;
          div_req.rem_init = DIV_W'(mul_prod[MUL_P_W-1:16]);
          div_req.num_low  = {mul_prod[15:0], 16'd0};
          div_req.divisor  = DIV_W'(NS_PER_SEC);
          state_nxt        = S_INC_DIV;
        end
      end
      S_INC_DIV: begin
        if (div_done) begin
          speed_nxt = sp_new;
          if (sp_capped) begin
            cap_step_nxt = pos_r;
            cap_nxt      = 1'b1;
          end
          div_req.start    = 1'b1;
          div_req.iters    = DIV_ITERS_DELAY;
          div_req.rem_init = DLY_REM_INIT;
          div_req.num_low  = DLY_NUM_LOW;
          div_req.divisor  = sp_new;
          state_nxt        = S_DLY_DIV;
        end
      end
      S_DLY_DIV: begin
        if (div_done) begin
          delay_nxt      = div_quot[DELAY_W-1:0];
          ram_we         = 1'b1;
          res_delay_nxt  = div_quot[DELAY_W-1:0];
          res_phase_nxt  = PH_ACCEL;
          res_idx_nxt    = IDX_W'(pos_r);
          res_pin_nxt    = ~pos_r[0];
          res_last_nxt   = (pos_inc == len_r);
          res_status_nxt = STATUS_OK;
          pos_nxt        = pos_inc;
          active_nxt     = (pos_inc < len_r);
          state_nxt      = S_OUT;
        end
      end
      S_RD: begin
        res_delay_nxt  = ram_rdata;
        res_phase_nxt  = PH_DECEL;
        res_idx_nxt    = IDX_W'(pos_r);
        res_pin_nxt    = ~pos_r[0];
        res_last_nxt   = (pos_inc == len_r);
        res_status_nxt = STATUS_OK;
        pos_nxt        = pos_inc;
        active_nxt     = (pos_inc < len_r);
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_delay_nxt  = res_delay_r;
          out_idx_nxt    = res_idx_r;
          out_phase_nxt  = res_phase_r;
          out_pin_nxt    = res_pin_r;
          out_last_nxt   = res_last_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      max_speed_r   <= MAXSP_W'(3000);
      start_speed_r <= MINSP_W'(10);
      speed_r       <= '0;
      delay_r       <= '0;
      pos_r         <= '0;
      len_r         <= '0;
      cap_step_r    <= '0;
      cap_r         <= 1'b0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      max_speed_r   <= max_speed_nxt;
      start_speed_r <= start_speed_nxt;
      speed_r       <= speed_nxt;
      delay_r       <= delay_nxt;
      pos_r         <= pos_nxt;
      len_r         <= len_nxt;
      cap_step_r    <= cap_step_nxt;
      cap_r         <= cap_nxt;
      active_r      <= active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_delay_r  <= res_delay_nxt;
    res_idx_r    <= res_idx_nxt;
    res_phase_r  <= res_phase_nxt;
    res_pin_r    <= res_pin_nxt;
    res_last_r   <= res_last_nxt;
    res_status_r <= res_status_nxt;
    out_delay_r  <= out_delay_nxt;
    out_idx_r    <= out_idx_nxt;
    out_phase_r  <= out_phase_nxt;
    out_pin_r    <= out_pin_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_delay_ns   = out_delay_r;
  assign out_step_index = out_idx_r;
  assign out_phase      = out_phase_r;
  assign out_pin_level  = out_pin_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

// File: rtl/core/stp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 32768,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/stp_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_serial_mul: bit-serial shift-add multiplier
// Takes one multiplier bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module stp_serial_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  stp_pkg::mul_req_t         req,
  output logic                      done,
  output logic [stp_pkg::MUL_P_W-1:0] product
);
  import stp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MUL_A_W-1:0]   a_r, a_nxt;
  logic [MUL_B_W-1:0]   b_r, b_nxt;
  logic [MUL_P_W-1:0]   acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MUL_CNT_W'(MUL_A_W);
      a_nxt    = req.mplier;
      b_nxt    = req.mcand;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[MUL_P_W-2:0], 1'b0}
              + (a_r[MUL_A_W-1] ? MUL_P_W'(b_r) : '0);
      a_nxt   = {a_r[MUL_A_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// File: rtl/core/stp_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_serial_div: restoring divider, one quotient bit per cycle
// The caller seeds the remainder with the numerator bits above the quotient
// positions; the low bits shift in while quotient bits shift out.
// ----------------------------------------------------------------------------
module stp_serial_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stp_pkg::div_req_t       req,
  output logic                    done,
  output logic [stp_pkg::DIV_W-1:0] quot
);
  import stp_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_ITER_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [DIV_W-1:0]      nq_r, nq_nxt;
  logic [DIV_W-1:0]      dvs_r, dvs_nxt;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W+1:0]      diff;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_r, nq_r[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = ~diff[DIV_W+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      rem_nxt  = req.rem_init;
      nq_nxt   = req.num_low;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      nq_nxt  = {nq_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = nq_r;

endmodule
